// ----- sv/tcce_pkg.sv -----
`default_nettype none

package tcce_pkg;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FILL,
        ST_BLANK,
        ST_READ,
        ST_LINE,
        ST_COPY,
        ST_SCROLL_END,
        ST_DONE
    } tcce_state_t;

    // Request kinds
    localparam logic [1:0] KIND_PUT   = 2'd0;
    localparam logic [1:0] KIND_MOVE  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    // Character codes
    localparam logic [7:0] CHAR_BLANK = 8'h20;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    // Register select (word address bit)
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // Width used for shown-area sizes and compares
    localparam int DIM_W = 9;

endpackage

`default_nettype wire

// ----- sv/tcce_ram.sv -----
`default_nettype none

module tcce_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 8192,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- sv/text_console_cell_engine.sv -----
`default_nettype none

// Text console cell map with cursor.
// Requests enter on in_valid/in_stall (kind, char_code, target_row, target_col);
// each request gives exactly one result on out_valid/out_stall (cursor_row,
// cursor_col, cell_value, scrolled). Shown rows/columns are set through the APB
// port (word 0 rows_in_use, word 1 cols_in_use); the user must write them only
// while no request is in flight, as the block does not enforce this. One request
// is worked at a time; in_stall is high from acceptance until the result is
// loaded into the output register, so the next request can be taken in the
// cycle in which out_valid rises. A line feed in a written row blanks it from
// the cursor to the last shown column; a first put into an untouched row
// writes all MAX_COLS cells of it, the byte and blanks. A scroll copies rows
// one cell a cycle through the single RAM read port; rows still untouched are
// not copied, only their flag is dropped. A result held by out_stall stays in
// the output register, and the next request is still accepted and worked; it
// waits in its last state until the output frees. Reset clears per-row written
// flags at once, so the map reads blank right after reset with no clearing
// pass; clear screen drops the flags too.

module text_console_cell_engine
    import tcce_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  kind,
    input  wire logic [7:0]  char_code,
    input  wire logic [5:0]  target_row,
    input  wire logic [6:0]  target_col,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [5:0]  cursor_row,
    output logic      [6:0]  cursor_col,
    output logic      [7:0]  cell_value,
    output logic             scrolled
);

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = MAX_ROWS * (2 ** CW);
    localparam logic [CW-1:0]    COL_LAST = CW'(MAX_COLS - 1);
    localparam logic [DIM_W-1:0] ROWS_MAX = DIM_W'(MAX_ROWS);
    localparam logic [DIM_W-1:0] COLS_MAX = DIM_W'(MAX_COLS);

    tcce_state_t state_reg, state_next;

    logic [6:0]          rows_cfg_reg;
    logic [7:0]          cols_cfg_reg;
    logic [RW-1:0]       cur_row_reg, cur_row_next;
    logic [CW-1:0]       cur_col_reg, cur_col_next;
    logic [CW-1:0]       col_cnt_reg, col_cnt_next;
    logic [RW-1:0]       copy_row_reg, copy_row_next;
    logic [MAX_ROWS-1:0] row_valid_reg, row_valid_next;
    logic                pend_reg, pend_next;
    logic [AW-1:0]       pend_addr_reg, pend_addr_next;

    logic [1:0]          kind_reg, kind_next;
    logic [7:0]          code_reg, code_next;
    logic [5:0]          trow_reg, trow_next;
    logic [6:0]          tcol_reg, tcol_next;
    logic [7:0]          value_reg, value_next;
    logic                scrolled_reg, scrolled_next;

    logic                out_valid_reg, out_valid_next;
    logic [5:0]          out_row_reg, out_row_next;
    logic [6:0]          out_col_reg, out_col_next;
    logic [7:0]          out_value_reg, out_value_next;
    logic                out_scrolled_reg, out_scrolled_next;

    logic [DIM_W-1:0]    rows_cfg_ext, cols_cfg_ext;
    logic [DIM_W-1:0]    rows_eff, cols_eff, rows_m1, cols_m1;
    logic [DIM_W-1:0]    cur_row_ext, cur_col_ext, trow_ext, tcol_ext, copy_row_ext;
    logic [RW-1:0]       trow_idx, src_row;
    logic [CW-1:0]       tcol_idx;
    logic                cur_row_valid;
    logic                col_wrap;

    logic                fsm_we;
    logic [AW-1:0]       fsm_waddr;
    logic [7:0]          fsm_wdata;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [7:0]          ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [7:0]          ram_rdata;
    logic                cfg_write;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= 7'd30;
            cols_cfg_reg <= 8'd80;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_ROWS: rows_cfg_reg <= pwdata[6:0];
                REG_COLS: cols_cfg_reg <= pwdata[7:0];
                default:  rows_cfg_reg <= rows_cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_ROWS: prdata = {25'd0, rows_cfg_reg};
            REG_COLS: prdata = {24'd0, cols_cfg_reg};
            default:  prdata = 32'd0;
        endcase
    end

    // Shown area, with zero acting as one and oversize as the maximum
    assign rows_cfg_ext = DIM_W'(rows_cfg_reg);
    assign cols_cfg_ext = DIM_W'(cols_cfg_reg);
    assign rows_eff = (rows_cfg_ext == '0) ? DIM_W'(1) :
                      (rows_cfg_ext > ROWS_MAX) ? ROWS_MAX : rows_cfg_ext;
    assign cols_eff = (cols_cfg_ext == '0) ? DIM_W'(1) :
                      (cols_cfg_ext > COLS_MAX) ? COLS_MAX : cols_cfg_ext;
    assign rows_m1  = rows_eff - DIM_W'(1);
    assign cols_m1  = cols_eff - DIM_W'(1);

    assign cur_row_ext  = DIM_W'(cur_row_reg);
    assign cur_col_ext  = DIM_W'(cur_col_reg);
    assign trow_ext     = DIM_W'(trow_reg);
    assign tcol_ext     = DIM_W'(tcol_reg);
    assign copy_row_ext = DIM_W'(copy_row_reg);
    assign trow_idx     = trow_ext[RW-1:0];
    assign tcol_idx     = tcol_ext[CW-1:0];
    assign src_row      = copy_row_reg + RW'(1);

    assign cur_row_valid = row_valid_reg[cur_row_reg];
    assign col_wrap      = (cur_col_ext == cols_m1);

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        cur_row_next      = cur_row_reg;
        cur_col_next      = cur_col_reg;
        col_cnt_next      = col_cnt_reg;
        copy_row_next     = copy_row_reg;
        row_valid_next    = row_valid_reg;
        pend_next         = 1'b0;
        pend_addr_next    = pend_addr_reg;
        kind_next         = kind_reg;
        code_next         = code_reg;
        trow_next         = trow_reg;
        tcol_next         = tcol_reg;
        value_next        = value_reg;
        scrolled_next     = scrolled_reg;
        out_valid_next    = out_valid_reg & out_stall;
        out_row_next      = out_row_reg;
        out_col_next      = out_col_reg;
        out_value_next    = out_value_reg;
        out_scrolled_next = out_scrolled_reg;
        fsm_we            = 1'b0;
        fsm_waddr         = {cur_row_reg, col_cnt_reg};
        fsm_wdata         = CHAR_BLANK;
        ram_raddr         = {trow_idx, tcol_idx};

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next     = kind;
                    code_next     = char_code;
                    trow_next     = target_row;
                    tcol_next     = target_col;
                    value_next    = 8'd0;
                    scrolled_next = 1'b0;
                    // saturate the cursor into the current shown area
                    if (cur_row_ext > rows_m1)
                    begin
                        cur_row_next = rows_m1[RW-1:0];
                    end
                    if (cur_col_ext > cols_m1)
                    begin
                        cur_col_next = cols_m1[CW-1:0];
                    end
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                case (kind_reg)
                    KIND_PUT:
                    begin
                        if (code_reg == CHAR_CR)
                        begin
                            cur_col_next = '0;
                            state_next   = ST_DONE;
                        end
                        else if (code_reg == CHAR_LF)
                        begin
                            if (cur_row_valid)
                            begin
                                col_cnt_next = cur_col_reg;
                                state_next   = ST_BLANK;
                            end
                            else
                            begin
                                cur_col_next = '0;
                                state_next   = ST_LINE;
                            end
                        end
                        else if (cur_row_valid)
                        begin
                            fsm_we    = 1'b1;
                            fsm_waddr = {cur_row_reg, cur_col_reg};
                            fsm_wdata = code_reg;
                            if (col_wrap)
                            begin
                                cur_col_next = '0;
                                state_next   = ST_LINE;
                            end
                            else
                            begin
                                cur_col_next = cur_col_reg + CW'(1);
                                state_next   = ST_DONE;
                            end
                        end
                        else
                        begin
                            // untouched row: fill with blanks and the byte
                            col_cnt_next = '0;
                            state_next   = ST_FILL;
                        end
                    end

                    KIND_MOVE:
                    begin
                        cur_row_next = (trow_ext < rows_eff) ? trow_idx : rows_m1[RW-1:0];
                        cur_col_next = (tcol_ext < cols_eff) ? tcol_idx : cols_m1[CW-1:0];
                        state_next   = ST_DONE;
                    end

                    KIND_READ:
                    begin
                        if (trow_ext < rows_eff && tcol_ext < cols_eff)
                        begin
                            state_next = ST_READ;
                        end
                        else
                        begin
                            value_next = CHAR_BLANK;
                            state_next = ST_DONE;
                        end
                    end

                    KIND_CLEAR:
                    begin
                        row_valid_next = '0;
                        cur_row_next   = '0;
                        cur_col_next   = '0;
                        state_next     = ST_DONE;
                    end

                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_FILL:
            begin
                fsm_we    = 1'b1;
                fsm_wdata = (col_cnt_reg == cur_col_reg) ? code_reg : CHAR_BLANK;
                if (col_cnt_reg == COL_LAST)
                begin
                    row_valid_next[cur_row_reg] = 1'b1;
                    if (col_wrap)
                    begin
                        cur_col_next = '0;
                        state_next   = ST_LINE;
                    end
                    else
                    begin
                        cur_col_next = cur_col_reg + CW'(1);
                        state_next   = ST_DONE;
                    end
                end
                else
                begin
                    col_cnt_next = col_cnt_reg + CW'(1);
                end
            end

            ST_BLANK:
            begin
                fsm_we = 1'b1;
                if (col_cnt_reg == cols_m1[CW-1:0])
                begin
                    cur_col_next = '0;
                    state_next   = ST_LINE;
                end
                else
                begin
                    col_cnt_next = col_cnt_reg + CW'(1);
                end
            end

            ST_READ:
            begin
                value_next = row_valid_reg[trow_idx] ? ram_rdata : CHAR_BLANK;
                state_next = ST_DONE;
            end

            ST_LINE:
            begin
                if (cur_row_ext == rows_m1)
                begin
                    scrolled_next = 1'b1;
                    copy_row_next = '0;
                    col_cnt_next  = '0;
                    state_next    = (rows_m1 == '0) ? ST_SCROLL_END : ST_COPY;
                end
                else
                begin
                    cur_row_next = cur_row_reg + RW'(1);
                    state_next   = ST_DONE;
                end
            end

            ST_COPY:
            begin
                ram_raddr = {src_row, col_cnt_reg};
                if (!row_valid_reg[src_row])
                begin
                    // source row still blank: drop the flag, no copy
                    row_valid_next[copy_row_reg] = 1'b0;
                    col_cnt_next = '0;
                    if (copy_row_ext + DIM_W'(1) == rows_m1)
                    begin
                        state_next = ST_SCROLL_END;
                    end
                    else
                    begin
                        copy_row_next = src_row;
                    end
                end
                else
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = {copy_row_reg, col_cnt_reg};
                    if (col_cnt_reg == COL_LAST)
                    begin
                        row_valid_next[copy_row_reg] = 1'b1;
                        col_cnt_next = '0;
                        if (copy_row_ext + DIM_W'(1) == rows_m1)
                        begin
                            state_next = ST_SCROLL_END;
                        end
                        else
                        begin
                            copy_row_next = src_row;
                        end
                    end
                    else
                    begin
                        col_cnt_next = col_cnt_reg + CW'(1);
                    end
                end
            end

            ST_SCROLL_END:
            begin
                row_valid_next[rows_m1[RW-1:0]] = 1'b0;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                // hold until the output register frees
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    out_row_next      = cur_row_ext[5:0];
                    out_col_next      = cur_col_ext[6:0];
                    out_value_next    = value_reg;
                    out_scrolled_next = scrolled_reg;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Copy writes land in the cycle after their read, through pend_reg
    assign ram_we    = pend_reg | fsm_we;
    assign ram_waddr = pend_reg ? pend_addr_reg : fsm_waddr;
    assign ram_wdata = pend_reg ? ram_rdata : fsm_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            col_cnt_reg   <= '0;
            copy_row_reg  <= '0;
            row_valid_reg <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            col_cnt_reg   <= col_cnt_next;
            copy_row_reg  <= copy_row_next;
            row_valid_reg <= row_valid_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg    <= pend_addr_next;
        kind_reg         <= kind_next;
        code_reg         <= code_next;
        trow_reg         <= trow_next;
        tcol_reg         <= tcol_next;
        value_reg        <= value_next;
        scrolled_reg     <= scrolled_next;
        out_row_reg      <= out_row_next;
        out_col_reg      <= out_col_next;
        out_value_reg    <= out_value_next;
        out_scrolled_reg <= out_scrolled_next;
    end

    tcce_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_cell_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign cursor_row = out_row_reg;
    assign cursor_col = out_col_reg;
    assign cell_value = out_value_reg;
    assign scrolled   = out_scrolled_reg;

endmodule

`default_nettype wire
